// File: rtl/core/hbk_pkg.sv
// Shared types, constants and key translation table for the HID boot keyboard decoder.
package hbk_pkg;

	localparam int unsigned KEY_SLOTS_DEF = 6;

	localparam logic [7:0] MOD_CTRL_MASK  = 8'h11;
	localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;

	localparam logic [7:0] KEY_RIGHT = 8'h4F;
	localparam logic [7:0] KEY_LEFT  = 8'h50;
	localparam logic [7:0] KEY_DOWN  = 8'h51;
	localparam logic [7:0] KEY_UP    = 8'h52;
	localparam logic [7:0] LETTER_A  = 8'h04;
	localparam logic [7:0] LETTER_Z  = 8'h1D;
	localparam logic [7:0] DIGIT_1   = 8'h1E;
	localparam logic [7:0] DIGIT_0   = 8'h27;

	localparam logic [6:0] CHAR_ESC     = 7'h1B;
	localparam logic [6:0] CHAR_BRACKET = 7'h5B;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	// Translation of one slot: byte count (0..3) and the byte at the asked index.
	typedef struct packed {
		logic [1:0] n;
		logic [6:0] code;
	} xlate_t;

	// Sequencer controls for one cycle.
	typedef struct packed {
		logic take;
		logic push;
		logic step;
		logic adv;
		logic out_ld;
		logic out_last;
		logic done;
	} seq_ctl_t;

	// ASCII for a usage ID; zero where the key gives nothing.
	function automatic logic [6:0] key_char(input logic [7:0] key, input logic shift);
		logic [6:0] c;
		c = 7'd0;
		if (key >= LETTER_A && key <= LETTER_Z) begin
			c = (shift ? 7'h41 : 7'h61) + 7'(key - LETTER_A);
		end else if (key >= DIGIT_1 && key < DIGIT_0 && !shift) begin
			c = 7'h31 + 7'(key - DIGIT_1);
		end else begin
			case (key)
				8'h1E: c = 7'h21;
				8'h1F: c = 7'h40;
				8'h20: c = 7'h23;
				8'h21: c = 7'h24;
				8'h22: c = 7'h25;
				8'h23: c = 7'h5E;
				8'h24: c = 7'h26;
				8'h25: c = 7'h2A;
				8'h26: c = 7'h28;
				8'h27: c = shift ? 7'h29 : 7'h30;
				8'h28: c = 7'd13;
				8'h29: c = 7'h1B;
				8'h2A: c = shift ? 7'd8 : 7'd127;
				8'h2B: c = 7'd9;
				8'h2C: c = 7'h20;
				8'h2D: c = shift ? 7'h5F : 7'h2D;
				8'h2E: c = shift ? 7'h2B : 7'h3D;
				8'h2F: c = shift ? 7'h7B : 7'h5B;
				8'h30: c = shift ? 7'h7D : 7'h5D;
				8'h31: c = shift ? 7'h7C : 7'h5C;
				8'h33: c = shift ? 7'h3A : 7'h3B;
				8'h34: c = shift ? 7'h22 : 7'h27;
				8'h35: c = shift ? 7'h7E : 7'h60;
				8'h36: c = shift ? 7'h3C : 7'h2C;
				8'h37: c = shift ? 7'h3E : 7'h2E;
				8'h38: c = shift ? 7'h3F : 7'h2F;
				default: c = 7'd0;
			endcase
		end
		return c;
	endfunction

endpackage

// File: rtl/core/hbk_xlate.sv
// Shared translation unit: one key slot to its byte count and the byte at a given index.
module hbk_xlate (
	input  logic [7:0]    key,
	input  logic          held,
	input  logic          ctrl,
	input  logic          shift,
	input  logic [1:0]    sub,
	output hbk_pkg::xlate_t res
);
	import hbk_pkg::*;

	logic       arrow;
	logic [6:0] arrow_ch;
	logic [6:0] ch;

	always_comb begin
		arrow    = 1'b1;
		arrow_ch = 7'h43;
		case (key)
			KEY_RIGHT: arrow_ch = 7'h43;
			KEY_LEFT:  arrow_ch = 7'h44;
			KEY_DOWN:  arrow_ch = 7'h42;
			KEY_UP:    arrow_ch = 7'h41;
			default:   arrow = 1'b0;
		endcase
	end

	// Ctrl maps letters to control codes, otherwise fall back to the table
	always_comb begin
		if (ctrl && key >= LETTER_A && key <= LETTER_Z) begin
			ch = 7'(key - LETTER_A) + 7'd1;
		end else begin
			ch = key_char(key, shift);
		end
	end

	always_comb begin
		res.n    = 2'd0;
		res.code = ch;
		if (key != 8'd0 && !held) begin
			if (arrow) begin
				res.n = 2'd3;
			end else if (ch != 7'd0) begin
				res.n = 2'd1;
			end
		end
		if (arrow) begin
			case (sub)
				2'd0:    res.code = CHAR_ESC;
				2'd1:    res.code = CHAR_BRACKET;
				default: res.code = arrow_ch;
			endcase
		end
	end

endmodule

// File: rtl/core/hid_boot_keyboard_to_ascii_top.sv
// Top level of the HID boot keyboard report to ASCII decoder.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata: modifier, key_0..key_N-1, report_len
//   m_*      out  m_tvalid/m_tready  m_tdata: char_code (pad bit 7), m_tlast: last
//
// A full report is accepted, then the one translation unit is stepped through
// the key slots: a slot that gives no byte is passed over, each emitted byte
// (at most 3 per slot) is pushed in turn, and a flush step ends the scan. A
// short report is taken and dropped without leaving idle.
// s_tready is high only while the sequencer is idle.
// The last byte of a report is held in a pending register until the scan ends,
// so its last flag is known; a stalled m_tready stalls the scan.
// arst_n clears the previous-key store, the sequencer and the valid flags.
module hid_boot_keyboard_to_ascii_top #(
	parameter int unsigned KEY_SLOTS = hbk_pkg::KEY_SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// modifier [7:0], key_i [8*i+15:8*i+8], report_len at the top byte
	input  logic [8*(KEY_SLOTS+2)-1:0] s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// char_code [6:0], zero [7]
	output logic [7:0]                 m_tdata,
	output logic                       m_tlast
);
	import hbk_pkg::*;

	localparam int unsigned IDX_W   = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam logic [7:0]  RPT_MIN = 8'(KEY_SLOTS + 2);

	state_t          state_q, state_d;
	seq_ctl_t        ctl;
	logic [IDX_W-1:0] slot_q;
	logic [1:0]      sub_q;
	logic            ctrl_q, shift_q;
	logic [7:0]      keys_q [KEY_SLOTS];
	logic [7:0]      prev_q [KEY_SLOTS];
	logic [6:0]      pend_q;
	logic            pend_vld_q;
	logic [6:0]      out_code_q;
	logic            out_last_q;
	logic            out_vld_q;

	logic [7:0]      rpt_len;
	logic [7:0]      rpt_mod;
	logic [7:0]      cur_key;
	logic            held;
	logic            has_byte;
	logic            last_slot;
	logic            out_free;
	xlate_t          xl;

	assign rpt_mod   = s_tdata[7:0];
	assign rpt_len   = s_tdata[8*(KEY_SLOTS+1) +: 8];
	assign cur_key   = keys_q[slot_q];
	assign last_slot = (slot_q == IDX_W'(KEY_SLOTS - 1));
	assign out_free  = !out_vld_q || m_tready;
	assign has_byte  = (sub_q < xl.n);

	// Key seen in the previous report: compare against every stored slot at once
	always_comb begin
		held = 1'b0;
		for (int j = 0; j < KEY_SLOTS; j++) begin
			if (prev_q[j] == cur_key) begin
				held = 1'b1;
			end
		end
	end

	hbk_xlate u_xlate (
		.key   (cur_key),
		.held  (held),
		.ctrl  (ctrl_q),
		.shift (shift_q),
		.sub   (sub_q),
		.res   (xl)
	);

	// Sequencer controls
	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.take = s_tvalid && (rpt_len >= RPT_MIN);
			end
			ST_SCAN: begin
				if (has_byte) begin
					// hold the scan while the pending byte cannot move out
					if (!pend_vld_q || out_free) begin
						ctl.push   = 1'b1;
						ctl.out_ld = pend_vld_q;
						if (sub_q == xl.n - 2'd1) begin
							ctl.adv = 1'b1;
						end else begin
							ctl.step = 1'b1;
						end
					end
				end else begin
					ctl.adv = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (!pend_vld_q) begin
					ctl.done = 1'b1;
				end else if (out_free) begin
					ctl.out_ld   = 1'b1;
					ctl.out_last = 1'b1;
					ctl.done     = 1'b1;
				end
			end
			default: ctl = '0;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (ctl.take) state_d = ST_SCAN;
			ST_SCAN:  if (ctl.adv && last_slot) state_d = ST_FLUSH;
			ST_FLUSH: if (ctl.done) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
			for (int j = 0; j < KEY_SLOTS; j++) begin
				prev_q[j] <= 8'd0;
			end
		end else begin
			state_q <= state_d;
			if (ctl.push) begin
				pend_vld_q <= 1'b1;
			end else if (ctl.out_ld) begin
				pend_vld_q <= 1'b0;
			end
			if (ctl.out_ld) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			// commit this report as the new reference at the end of the scan
			if (ctl.done) begin
				prev_q <= keys_q;
			end
		end
	end

	// Payload and slot counters
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				keys_q[i] <= s_tdata[8*(i+1) +: 8];
			end
			ctrl_q  <= (rpt_mod & MOD_CTRL_MASK) != 8'd0;
			shift_q <= (rpt_mod & MOD_SHIFT_MASK) != 8'd0;
			slot_q  <= '0;
			sub_q   <= 2'd0;
		end
		if (ctl.step) begin
			sub_q <= sub_q + 2'd1;
		end
		if (ctl.adv) begin
			sub_q <= 2'd0;
			if (!last_slot) begin
				slot_q <= slot_q + IDX_W'(1);
			end
		end
		if (ctl.push) begin
			pend_q <= xl.code;
		end
		if (ctl.out_ld) begin
			out_code_q <= pend_q;
			out_last_q <= ctl.out_last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_code_q};
	assign m_tlast  = out_last_q;

endmodule

// File: rtl/core/hbk_check.sv
// Port-level checker for the HID boot keyboard decoder, bound to the top level.
module hbk_check #(
	parameter int unsigned KEY_SLOTS = hbk_pkg::KEY_SLOTS_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic [8*(KEY_SLOTS+2)-1:0] s_tdata,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [7:0]                 m_tdata,
	input logic                       m_tlast
);
	localparam logic [7:0] RPT_MIN = 8'(KEY_SLOTS + 2);

	logic [7:0] len;
	assign len = s_tdata[8*(KEY_SLOTS+1) +: 8];

	// Stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// A full report starts a scan that blocks the input
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && len >= RPT_MIN |=> !s_tready)
		else $error("input ready right after a full report");

	// A short report is dropped and the input stays open
	a_short_drop: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && len < RPT_MIN |=> s_tready)
		else $error("short report was not dropped");

	// Output bytes are 7-bit ASCII
	a_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[7])
		else $error("pad bit set in output word");

endmodule

bind hid_boot_keyboard_to_ascii_top hbk_check #(.KEY_SLOTS(KEY_SLOTS)) u_hbk_check (.*);
